// File: rtl/psa_pkg.sv
// shared types and constants of the preferential attachment sampler
// used by psa_ctrl, psa_datapath and preferential_attachment_sampler_top
// no dependencies
package psa_pkg;

  // fixed field widths
  localparam int RAND_W      = 32;
  localparam int NODE_FIELD_W = 10;
  localparam int SEED_W      = 5;
  localparam int EDGES_W     = 5;
  localparam int TOTAL_W     = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_DATA_W  = 24;

  // register clamp limits
  localparam int SEED_MIN  = 2;
  localparam int SEED_MAX  = 16;
  localparam int EDGES_MIN = 1;
  localparam int EDGES_MAX = 16;
  localparam int TOTAL_MIN = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EDGES      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_TOTAL = 2'd2;

  // register reset values
  localparam logic [SEED_W-1:0]  SEED_RESET  = 5'd3;
  localparam logic [EDGES_W-1:0] EDGES_RESET = 5'd2;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_SCAN,
    ST_WR_CHOSEN,
    ST_COMMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic reseed;
    logic load_item;
    logic start_scan;
    logic scan_en;
    logic wr_chosen;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// File: rtl/psa_ctrl.sv
// controller state machine of the preferential attachment sampler
// sequences threshold multiply, degree scan, memory updates and result handoff
// depends on psa_pkg
module psa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             reseed_req,
  input  logic             out_free,
  input  psa_pkg::status_t status,
  output psa_pkg::cmd_t    cmd
);

  psa_pkg::state_t state;
  psa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      psa_pkg::ST_IDLE: begin
        cmd.reseed = reseed_req;
        in_ready   = !reseed_req;
        if (in_valid && !reseed_req) begin
          cmd.load_item = 1'b1;
          state_next    = psa_pkg::ST_MULT;
        end
      end
      psa_pkg::ST_MULT: begin
        cmd.start_scan = 1'b1;
        state_next     = psa_pkg::ST_SCAN;
      end
      psa_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_next = psa_pkg::ST_WR_CHOSEN;
        end
      end
      psa_pkg::ST_WR_CHOSEN: begin
        cmd.wr_chosen = 1'b1;
        state_next    = psa_pkg::ST_COMMIT;
      end
      psa_pkg::ST_COMMIT: begin
        // hold here until the output register can take the result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = psa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/psa_datapath.sv
// datapath of the preferential attachment sampler: degree memory, graph counters,
// threshold multiplier and cumulative degree scan
// depends on psa_pkg
module psa_datapath #(
  parameter int MAX_NODES   = 1024,
  parameter int DEGREE_BITS = 16,
  localparam int NODE_BITS  = $clog2(MAX_NODES),
  localparam int CNT_BITS   = $clog2(MAX_NODES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  psa_pkg::cmd_t               cmd,
  input  logic [psa_pkg::RAND_W-1:0]  rand_in,
  input  logic [psa_pkg::SEED_W-1:0]  eff_seed,
  input  logic [psa_pkg::EDGES_W-1:0] eff_edges,
  input  logic [CNT_BITS-1:0]         eff_total,
  output psa_pkg::status_t            status,
  output logic [NODE_BITS-1:0]        res_new_node,
  output logic [NODE_BITS-1:0]        res_chosen,
  output logic                        res_complete,
  output logic                        res_done
);

  localparam int CUM_BITS  = DEGREE_BITS + NODE_BITS;
  localparam int SLOTS     = (MAX_NODES < psa_pkg::SEED_MAX) ? MAX_NODES : psa_pkg::SEED_MAX;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int PROD_BITS = psa_pkg::RAND_W + DEGREE_BITS;
  localparam logic [DEGREE_BITS-1:0] DEG_MAX = '1;

  logic [DEGREE_BITS-1:0] mem [MAX_NODES];

  logic [psa_pkg::RAND_W-1:0]  rand_q;
  logic [DEGREE_BITS-1:0]      thr;
  logic [DEGREE_BITS-1:0]      total;
  logic [NODE_BITS-1:0]        cur_node;
  logic [psa_pkg::EDGES_W-1:0] edge_idx;
  logic [DEGREE_BITS-1:0]      cur_deg;
  logic [SLOTS-1:0]            seed_valid;

  logic [NODE_BITS-1:0]   rd_addr;
  logic [NODE_BITS-1:0]   rd_idx;
  logic [DEGREE_BITS-1:0] rd_data;
  logic                   rd_live;
  logic                   rd_fresh;
  logic                   rd_seed;
  logic [CUM_BITS-1:0]    cum;
  logic [NODE_BITS-1:0]   chosen;
  logic [DEGREE_BITS-1:0] chosen_deg;

  logic [PROD_BITS-1:0]        prod;
  logic                        issue_fresh;
  logic                        issue_seed;
  logic [DEGREE_BITS-1:0]      seed_deg;
  logic [DEGREE_BITS-1:0]      deg_val;
  logic [CUM_BITS-1:0]         cum_sum;
  logic                        hit;
  logic                        last;
  logic [psa_pkg::EDGES_W-1:0] edge_inc;
  logic [CNT_BITS-1:0]         node_inc;
  logic                        complete;
  logic                        done;
  logic                        do_reseed;
  logic [DEGREE_BITS:0]        total_add;
  logic [DEGREE_BITS-1:0]      total_inc;
  logic [DEGREE_BITS-1:0]      cur_deg_inc;
  logic [DEGREE_BITS-1:0]      chosen_deg_inc;
  logic [9:0]                  clique_sum;
  logic                        mem_we;
  logic [NODE_BITS-1:0]        mem_waddr;
  logic [DEGREE_BITS-1:0]      mem_wdata;

  always_comb begin
    prod = PROD_BITS'(rand_q) * PROD_BITS'(total);

    // entries written since the last reseed read from memory, others from the clique image
    if (32'(rd_addr) < SLOTS) begin
      issue_fresh = seed_valid[rd_addr[SLOT_BITS-1:0]];
    end else begin
      issue_fresh = 1'b1;
    end
    issue_seed = 32'(rd_addr) < 32'(eff_seed);
    seed_deg   = DEGREE_BITS'(eff_seed - 5'd1);

    if (rd_fresh) begin
      deg_val = rd_data;
    end else if (rd_seed) begin
      deg_val = seed_deg;
    end else begin
      deg_val = '0;
    end
    cum_sum = cum + CUM_BITS'(deg_val);
    hit     = cum_sum > CUM_BITS'(thr);
    // node i-1 takes the edge when no earlier node qualifies
    last    = rd_idx == (cur_node - NODE_BITS'(1));
    status.scan_done = cmd.scan_en && rd_live && (hit || last);

    edge_inc  = edge_idx + 5'd1;
    complete  = edge_inc >= eff_edges;
    node_inc  = CNT_BITS'(cur_node) + CNT_BITS'(1);
    done      = complete && (node_inc >= eff_total);
    do_reseed = cmd.reseed || (cmd.commit && done);

    total_add      = {1'b0, total} + (DEGREE_BITS + 1)'(2);
    total_inc      = total_add[DEGREE_BITS] ? DEG_MAX : total_add[DEGREE_BITS-1:0];
    cur_deg_inc    = (cur_deg == DEG_MAX) ? cur_deg : cur_deg + DEGREE_BITS'(1);
    chosen_deg_inc = (chosen_deg == DEG_MAX) ? chosen_deg : chosen_deg + DEGREE_BITS'(1);
    clique_sum     = 10'(eff_seed) * 10'(eff_seed - 5'd1);

    mem_we    = cmd.wr_chosen || cmd.commit;
    mem_waddr = cmd.wr_chosen ? chosen : cur_node;
    mem_wdata = cmd.wr_chosen ? chosen_deg_inc : cur_deg_inc;

    res_new_node = cur_node;
    res_chosen   = chosen;
    res_complete = complete;
    res_done     = done;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rand_q <= rand_in;
    end
    if (cmd.start_scan) begin
      thr     <= prod[PROD_BITS-1:psa_pkg::RAND_W];
      rd_addr <= '0;
      cum     <= '0;
    end else if (cmd.scan_en) begin
      rd_addr  <= rd_addr + NODE_BITS'(1);
      rd_idx   <= rd_addr;
      rd_fresh <= issue_fresh;
      rd_seed  <= issue_seed;
      if (rd_live) begin
        cum <= cum_sum;
      end
    end
    if (status.scan_done) begin
      chosen     <= rd_idx;
      chosen_deg <= deg_val;
    end
  end

  // graph state
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      cur_node   <= '0;
      edge_idx   <= '0;
      cur_deg    <= '0;
      seed_valid <= '0;
      rd_live    <= 1'b0;
    end else begin
      if (cmd.start_scan) begin
        rd_live <= 1'b0;
      end else if (cmd.scan_en) begin
        rd_live <= 1'b1;
      end

      if (do_reseed) begin
        total      <= DEGREE_BITS'(clique_sum);
        cur_node   <= NODE_BITS'(eff_seed);
        edge_idx   <= '0;
        cur_deg    <= '0;
        seed_valid <= '0;
      end else if (cmd.commit) begin
        total <= total_inc;
        if (32'(cur_node) < SLOTS) begin
          seed_valid[cur_node[SLOT_BITS-1:0]] <= 1'b1;
        end
        if (complete) begin
          edge_idx <= '0;
          cur_deg  <= '0;
          cur_node <= node_inc[NODE_BITS-1:0];
        end else begin
          edge_idx <= edge_inc;
          cur_deg  <= cur_deg_inc;
        end
      end else if (cmd.wr_chosen) begin
        if (32'(chosen) < SLOTS) begin
          seed_valid[chosen[SLOT_BITS-1:0]] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/preferential_attachment_sampler_top.sv
// Preferential attachment sampler, top level. One random word in, one graph edge out.
//
// Channels: s_* carries random_fraction (a fraction of 2^32). m_* carries the edge:
// the new node, the existing node it attaches to, a flag for the new node's last
// edge, and m_tlast on the edge that completes the network. cfg_we/cfg_index/cfg_data
// write seed_count (0), edges_per_new_node (1) and node_total (2); any such write
// restarts the network from a fresh seed clique. Write only while the block is idle.
// Timing: one item at a time; the next item is taken only after the result of the last
// one is committed. An item's time from transfer in to result in the output register
// grows with the index of its chosen node and is set by the serial scan of
// cumulative degrees through the one read port of the degree memory, one node per
// cycle, plus a multiply and two memory writes.
// Reset: synchronous, active high; the degree store is reseeded in the first cycle
// after reset (s_tready low there and in the cycle after a register write).
// Stall: the result waits in the output register; a new item may be taken meanwhile,
// and its result waits in the datapath until the output register is free.
// depends on psa_pkg, psa_ctrl and psa_datapath
module preferential_attachment_sampler_top #(
  parameter int MAX_NODES   = 1024,
  parameter int DEGREE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [psa_pkg::RAND_W-1:0]      s_tdata,   // [31:0] random_fraction
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psa_pkg::OUT_DATA_W-1:0]  m_tdata,   // [9:0] new_node, [19:10] chosen_node,
                                                     // [20] node_complete, [23:21] zero
  output logic                            m_tlast,   // network_done
  input  logic                            cfg_we,
  input  logic [psa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = $clog2(MAX_NODES + 1);

  logic [psa_pkg::SEED_W-1:0]  seed_count;
  logic [psa_pkg::EDGES_W-1:0] edges_per_new_node;
  logic [psa_pkg::TOTAL_W-1:0] node_total;
  logic                        reseed_pend;

  logic [psa_pkg::SEED_W-1:0]  eff_seed;
  logic [psa_pkg::EDGES_W-1:0] eff_edges;
  logic [CNT_BITS-1:0]         eff_total;
  logic [31:0]                 total_c;
  logic [31:0]                 seed_c;
  logic [31:0]                 edges_c;

  psa_pkg::cmd_t    cmd;
  psa_pkg::status_t status;
  logic             out_free;

  logic [NODE_BITS-1:0] dp_new_node;
  logic [NODE_BITS-1:0] dp_chosen;
  logic                 dp_complete;
  logic                 dp_done;
  logic [31:0]          new_wide;
  logic [31:0]          chosen_wide;

  logic [psa_pkg::NODE_FIELD_W-1:0] out_new;
  logic [psa_pkg::NODE_FIELD_W-1:0] out_chosen;
  logic                             out_complete;
  logic                             out_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count         <= psa_pkg::SEED_RESET;
      edges_per_new_node <= psa_pkg::EDGES_RESET;
      node_total         <= psa_pkg::TOTAL_RESET;
      reseed_pend        <= 1'b1;
    end else begin
      reseed_pend <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          psa_pkg::REG_SEED_COUNT: begin
            seed_count  <= cfg_data[psa_pkg::SEED_W-1:0];
            reseed_pend <= 1'b1;
          end
          psa_pkg::REG_EDGES: begin
            edges_per_new_node <= cfg_data[psa_pkg::EDGES_W-1:0];
            reseed_pend        <= 1'b1;
          end
          psa_pkg::REG_NODE_TOTAL: begin
            node_total  <= cfg_data;
            reseed_pend <= 1'b1;
          end
          default: begin
            reseed_pend <= 1'b0;
          end
        endcase
      end
    end
  end

  // clamp the registers to usable values
  always_comb begin
    total_c = 32'(node_total);
    if (total_c < psa_pkg::TOTAL_MIN) total_c = psa_pkg::TOTAL_MIN;
    if (total_c > MAX_NODES) total_c = MAX_NODES;
    seed_c = 32'(seed_count);
    if (seed_c < psa_pkg::SEED_MIN) seed_c = psa_pkg::SEED_MIN;
    if (seed_c > psa_pkg::SEED_MAX) seed_c = psa_pkg::SEED_MAX;
    if (seed_c > total_c - 32'd1) seed_c = total_c - 32'd1;
    edges_c = 32'(edges_per_new_node);
    if (edges_c < psa_pkg::EDGES_MIN) edges_c = psa_pkg::EDGES_MIN;
    if (edges_c > psa_pkg::EDGES_MAX) edges_c = psa_pkg::EDGES_MAX;
    eff_total = CNT_BITS'(total_c);
    eff_seed  = psa_pkg::SEED_W'(seed_c);
    eff_edges = psa_pkg::EDGES_W'(edges_c);
  end

  assign out_free = !m_tvalid || m_tready;

  psa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .reseed_req (reseed_pend),
    .out_free   (out_free),
    .status     (status),
    .cmd        (cmd)
  );

  psa_datapath #(
    .MAX_NODES   (MAX_NODES),
    .DEGREE_BITS (DEGREE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rand_in      (s_tdata),
    .eff_seed     (eff_seed),
    .eff_edges    (eff_edges),
    .eff_total    (eff_total),
    .status       (status),
    .res_new_node (dp_new_node),
    .res_chosen   (dp_chosen),
    .res_complete (dp_complete),
    .res_done     (dp_done)
  );

  // node indexes go out as 10-bit fields
  assign new_wide    = 32'(dp_new_node);
  assign chosen_wide = 32'(dp_chosen);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_new      <= new_wide[psa_pkg::NODE_FIELD_W-1:0];
      out_chosen   <= chosen_wide[psa_pkg::NODE_FIELD_W-1:0];
      out_complete <= dp_complete;
      out_done     <= dp_done;
    end
  end

  assign m_tdata = {3'b000, out_complete, out_chosen, out_new};
  assign m_tlast = out_done;

  // the chosen node is always an older node
  a_chosen_older: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> dp_chosen < dp_new_node)
    else $error("chosen node not older than new node");

  // a finished network always ends a node
  a_done_ends_node: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && dp_done |-> dp_complete)
    else $error("network done without node complete");

  // no input transfer while the store is being reseeded
  a_no_take_on_reseed: assert property (@(posedge clk) disable iff (rst)
    reseed_pend |-> !s_tready)
    else $error("input taken during reseed");

  // a committed edge shows up in the output register
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed result not presented");

endmodule
